FILE: rtl/core/acft_pkg.sv
package acft_pkg;

  localparam int unsigned CELLS  = 1024;
  localparam int unsigned CELL_W = $clog2(CELLS);
  localparam int unsigned Q_W    = 16;
  localparam int unsigned CNT_W  = 32;
  localparam int unsigned RAW_W  = 18;
  localparam int unsigned IN_W   = 80;
  localparam int unsigned OUT_W  = 64;
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;

  localparam logic [Q_W-1:0] UNIT           = 16'd32768;
  localparam logic [Q_W-1:0] RISE_GAIN_INIT = 16'd22938;
  localparam logic [Q_W-1:0] FALL_GAIN_INIT = 16'd4915;

  typedef enum logic {
    REG_RISE_GAIN = 1'b0,
    REG_FALL_GAIN = 1'b1
  } reg_index_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_UPDATE
  } ctrl_state_e;

  typedef struct packed {
    logic             valid;
    logic [Q_W-1:0]   cost;
    logic [Q_W-1:0]   conf;
    logic [CNT_W-1:0] count;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic clear;
    logic accept;
    logic stage;
    logic commit;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
    logic out_free;
  } dp_sts_t;

endpackage

FILE: rtl/core/acft_ram.sv
module acft_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/acft_ctrl.sv
module acft_ctrl
  import acft_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clear_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_READ;
      end
      ST_READ: begin
        state_d = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_READ: begin
        cmd_o.stage = 1'b1;
      end
      ST_UPDATE: begin
        cmd_o.commit = sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

FILE: rtl/core/acft_datapath.sv
module acft_datapath
  import acft_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dp_cmd_t           cmd_i,
  output dp_sts_t           sts_o,
  input  logic [IN_W-1:0]   in_data_i,
  input  logic              in_user_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [OUT_W-1:0]  out_data_o,
  output logic              out_user_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata
);

  function automatic logic [Q_W-1:0] clamp_q(input logic [RAW_W-1:0] raw);
    logic [Q_W-1:0] res;
    if (raw[RAW_W-1]) begin
      res = '0;
    end else if (raw > {2'b00, UNIT}) begin
      res = UNIT;
    end else begin
      res = raw[Q_W-1:0];
    end
    return res;
  endfunction

  logic [Q_W-1:0] rise_gain_q, fall_gain_q;
  logic           cfg_wr;

  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_gain_q <= RISE_GAIN_INIT;
      fall_gain_q <= FALL_GAIN_INIT;
    end else if (cfg_wr) begin
      if (reg_index_e'(paddr[2]) == REG_RISE_GAIN) begin
        rise_gain_q <= pwdata[Q_W-1:0];
      end else begin
        fall_gain_q <= pwdata[Q_W-1:0];
      end
    end
  end

  assign prdata = (reg_index_e'(paddr[2]) == REG_RISE_GAIN)
                ? {{(DATA_W-Q_W){1'b0}}, rise_gain_q}
                : {{(DATA_W-Q_W){1'b0}}, fall_gain_q};

  logic [CELL_W-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clear) begin
      clr_cnt_q <= clr_cnt_q + 1'b1;
    end
  end

  assign sts_o.clear_last = (clr_cnt_q == CELL_W'(CELLS - 1));

  logic [CELL_W-1:0] cell_q;
  logic              finite_q;
  logic [Q_W-1:0]    meas_q, conf_q;
  logic [CNT_W-1:0]  samples_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      cell_q    <= in_data_i[CELL_W-1:0];
      finite_q  <= in_user_i;
      meas_q    <= clamp_q(in_data_i[27:10]);
      conf_q    <= clamp_q(in_data_i[45:28]);
      samples_q <= in_data_i[77:46];
    end
  end

  entry_t            rd_ent, wr_ent;
  logic              ram_we;
  logic [CELL_W-1:0] ram_waddr;
  logic [ENTRY_W-1:0] ram_rdata;

  acft_ram #(
    .Width(ENTRY_W),
    .Depth(CELLS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(wr_ent),
    .raddr_i(in_data_i[CELL_W-1:0]),
    .rdata_o(ram_rdata)
  );

  assign rd_ent = entry_t'(ram_rdata);

  entry_t           ent_q;
  logic             up_q;
  logic [Q_W-1:0]   weight_q, diff_q;
  logic [CNT_W-1:0] sum_q;

  logic             up_s1;
  logic [Q_W-1:0]   gain_s1, gain_lim_s1;
  logic [2*Q_W-1:0] wprod_s1;
  logic [CNT_W:0]   sum_s1;

  always_comb begin
    up_s1       = meas_q >= rd_ent.cost;
    gain_s1     = up_s1 ? rise_gain_q : fall_gain_q;
    gain_lim_s1 = (gain_s1 > UNIT) ? UNIT : gain_s1;
    wprod_s1    = gain_lim_s1 * conf_q;
    sum_s1      = {1'b0, rd_ent.count} + {1'b0, samples_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.stage) begin
      ent_q    <= rd_ent;
      up_q     <= up_s1;
      weight_q <= wprod_s1[30:15];
      diff_q   <= up_s1 ? meas_q - rd_ent.cost : rd_ent.cost - meas_q;
      sum_q    <= sum_s1[CNT_W] ? {CNT_W{1'b1}} : sum_s1[CNT_W-1:0];
    end
  end

  logic [2*Q_W-1:0]   step_prod;
  logic [Q_W-1:0]     step, cost_new, conf_new;
  logic [Q_W:0]       conf_gap;
  logic [2*Q_W:0]     conf_prod;
  logic [Q_W+1:0]     conf_sum;
  entry_t             out_ent;
  logic               out_ign;

  always_comb begin
    step_prod = weight_q * diff_q;
    step      = step_prod[30:15];
    cost_new  = up_q ? ent_q.cost + step : ent_q.cost - step;
    conf_gap  = {1'b0, UNIT} - {1'b0, ent_q.conf};
    conf_prod = conf_gap * conf_q;
    conf_sum  = {2'b00, ent_q.conf} + conf_prod[2*Q_W:15];
    conf_new  = (conf_sum > {2'b00, UNIT}) ? UNIT : conf_sum[Q_W-1:0];

    out_ign = !finite_q;
    if (!finite_q) begin
      out_ent = ent_q.valid ? ent_q : '0;
    end else if (!ent_q.valid) begin
      out_ent = '{valid: 1'b1, cost: meas_q, conf: conf_q, count: samples_q};
    end else begin
      out_ent = '{valid: 1'b1, cost: cost_new, conf: conf_new, count: sum_q};
    end
  end

  always_comb begin
    ram_we    = cmd_i.clear | (cmd_i.commit & finite_q);
    ram_waddr = cmd_i.clear ? clr_cnt_q : cell_q;
    wr_ent    = cmd_i.clear ? '0 : out_ent;
  end

  logic             out_valid_q;
  logic             out_ign_q;
  logic [OUT_W-1:0] out_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_ign_q  <= out_ign;
      out_data_q <= {out_ent.count, out_ent.conf, out_ent.cost};
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign out_data_o     = out_data_q;
  assign out_user_o     = out_ign_q;

endmodule

FILE: rtl/core/asymmetric_cost_filter_table.sv
// Channel   Dir  Handshake               Payload
// s_axis    in   tvalid/tready           tdata: cell_index, measured_cost_in,
//                                        input_confidence, sample_count;
//                                        tuser: measured_finite
// m_axis    out  tvalid/tready           tdata: cost_out, confidence_out,
//                                        observations_out; tuser: ignored
// apb       in   psel/penable/pready     rise_gain at 0x0, fall_gain at 0x4
//
// An item goes through table read, gain and weight products, step product and
// write-back, bound by the read-modify-write of the single table RAM.
// After reset the valid marks of all 1024 table cells are swept clear with
// s_axis_tready low; register writes are taken throughout.
// A result waits in the output register; the next item is taken meanwhile,
// and write-back stalls only while the previous result is still untaken.
module asymmetric_cost_filter_table
  import acft_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // [9:0] cell_index, [27:10] measured_cost_in, [45:28] input_confidence,
  // [77:46] sample_count, [79:78] zero
  input  logic [IN_W-1:0]   s_axis_tdata,
  // [0] measured_finite
  input  logic              s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // [15:0] cost_out, [31:16] confidence_out, [63:32] observations_out
  output logic [OUT_W-1:0]  m_axis_tdata,
  // [0] ignored
  output logic              m_axis_tuser,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign pready = 1'b1;

  acft_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_ready_o(s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  acft_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (s_axis_tdata),
    .in_user_i  (s_axis_tuser),
    .out_valid_o(m_axis_tvalid),
    .out_ready_i(m_axis_tready),
    .out_data_o (m_axis_tdata),
    .out_user_o (m_axis_tuser),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata)
  );

endmodule

FILE: rtl/core/acft_checker.sv
module acft_checker
  import acft_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tvalid,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [OUT_W-1:0] m_axis_tdata
);

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while an item is in flight");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped or changed while stalled");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without an item at work");

  a_values_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:0] <= UNIT && m_axis_tdata[31:16] <= UNIT)
    else $error("cost or confidence above one");

endmodule

bind asymmetric_cost_filter_table acft_checker u_acft_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);

FILE: tb/sv/asymmetric_cost_filter_table_test.sv
`timescale 1ns / 1ps

module asymmetric_cost_filter_table_test;
  import acft_pkg::*;

  localparam int unsigned IDLE_LIMIT = 4000;

  typedef struct {
    logic [CELL_W-1:0] idx;
    logic              finite;
    logic [RAW_W-1:0]  cost_raw;
    logic [RAW_W-1:0]  conf_raw;
    logic [CNT_W-1:0]  samples;
  } cell_obs_t;

  typedef struct {
    logic             ignored;
    logic [Q_W-1:0]   cost;
    logic [Q_W-1:0]   conf;
    logic [CNT_W-1:0] count;
  } cell_snapshot_t;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  // [9:0] cell_index, [27:10] measured_cost_in, [45:28] input_confidence,
  // [77:46] sample_count, [79:78] zero
  logic [IN_W-1:0]   s_axis_tdata;
  // [0] measured_finite
  logic              s_axis_tuser;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  // [15:0] cost_out, [31:16] confidence_out, [63:32] observations_out
  logic [OUT_W-1:0]  m_axis_tdata;
  // [0] ignored
  logic              m_axis_tuser;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  bit             cell_valid [CELLS];
  logic [Q_W-1:0]   cell_cost  [CELLS];
  logic [Q_W-1:0]   cell_conf  [CELLS];
  logic [CNT_W-1:0] cell_count [CELLS];
  logic [Q_W-1:0]   rise_gain_q;
  logic [Q_W-1:0]   fall_gain_q;

  cell_snapshot_t pending_cells [$];

  int mismatch_cnt;
  int obs_sent;
  int updates_seen;
  int dropped_cnt;
  int saturated_cnt;
  int reg_writes;
  int idle_cycles;
  int sink_hold;
  bit send_pace;
  bit sink_pace;

  asymmetric_cost_filter_table u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [Q_W-1:0] clamp_q(input logic [RAW_W-1:0] raw);
    if (raw[RAW_W-1]) return '0;
    if (raw > RAW_W'(UNIT)) return UNIT;
    return raw[Q_W-1:0];
  endfunction

  function automatic cell_obs_t mk_obs(input int idx, input bit finite, input int cost,
                                       input int conf, input longint samples);
    cell_obs_t o;
    o.idx      = CELL_W'(idx);
    o.finite   = finite;
    o.cost_raw = RAW_W'(cost);
    o.conf_raw = RAW_W'(conf);
    o.samples  = CNT_W'(samples);
    return o;
  endfunction

  function automatic logic [RAW_W-1:0] rand_q();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return RAW_W'($urandom_range(0, 32768));
    if (r < 90) begin
      case ($urandom_range(0, 3))
        0: return '0;
        1: return RAW_W'(32767);
        2: return RAW_W'(32768);
        default: return RAW_W'(32769);
      endcase
    end
    return RAW_W'($urandom);
  endfunction

  function automatic cell_obs_t rand_obs(input int lo, input int hi, input int drop_pct);
    cell_obs_t o;
    int r;
    o.idx      = CELL_W'($urandom_range(lo, hi));
    o.finite   = ($urandom_range(0, 99) >= drop_pct);
    o.cost_raw = rand_q();
    o.conf_raw = rand_q();
    r = $urandom_range(0, 99);
    if (r < 70) o.samples = CNT_W'($urandom_range(0, 1000));
    else if (r < 85) o.samples = CNT_W'($urandom);
    else o.samples = 32'hFFFF_FFFF - CNT_W'($urandom_range(0, 3));
    return o;
  endfunction

  task automatic apply_observation(input cell_obs_t o);
    cell_snapshot_t r;
    logic [Q_W-1:0] meas;
    logic [Q_W-1:0] wt;
    longint unsigned cost, conf, gain, weight, diff, step, sum;
    bit up;
    meas = clamp_q(o.cost_raw);
    wt   = clamp_q(o.conf_raw);
    r.ignored = !o.finite;
    if (!o.finite) begin
      dropped_cnt++;
      if (cell_valid[o.idx]) begin
        r.cost  = cell_cost[o.idx];
        r.conf  = cell_conf[o.idx];
        r.count = cell_count[o.idx];
      end else begin
        r.cost  = '0;
        r.conf  = '0;
        r.count = '0;
      end
    end else begin
      if (!cell_valid[o.idx]) begin
        cell_valid[o.idx] = 1'b1;
        cell_cost[o.idx]  = meas;
        cell_conf[o.idx]  = wt;
        cell_count[o.idx] = o.samples;
      end else begin
        cost = cell_cost[o.idx];
        conf = cell_conf[o.idx];
        up   = (meas >= cost);
        gain = up ? rise_gain_q : fall_gain_q;
        if (gain > UNIT) gain = UNIT;
        weight = (gain * wt) >> 15;
        diff   = up ? meas - cost : cost - meas;
        step   = (weight * diff) >> 15;
        cost   = up ? cost + step : cost - step;
        conf   = conf + (((UNIT - conf) * wt) >> 15);
        if (conf > UNIT) conf = UNIT;
        sum = longint'(cell_count[o.idx]) + longint'(o.samples);
        if (sum > 64'hFFFF_FFFF) begin
          sum = 64'hFFFF_FFFF;
          saturated_cnt++;
        end
        cell_cost[o.idx]  = Q_W'(cost);
        cell_conf[o.idx]  = Q_W'(conf);
        cell_count[o.idx] = CNT_W'(sum);
      end
      r.cost  = cell_cost[o.idx];
      r.conf  = cell_conf[o.idx];
      r.count = cell_count[o.idx];
    end
    pending_cells = {pending_cells, r};
  endtask

  task automatic send_obs(input cell_obs_t o);
    int gap;
    gap = (send_pace && $urandom_range(0, 99) < 40) ? gap_len() : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, o.samples, o.conf_raw, o.cost_raw, o.idx};
    s_axis_tuser  <= o.finite;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    apply_observation(o);
    obs_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_gain(input reg_index_e idx, input logic [Q_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(idx) << 2;
    pwdata  <= {16'($urandom), value};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx == REG_RISE_GAIN) rise_gain_q = value;
    else fall_gain_q = value;
    reg_writes++;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_batch(input int n, input int lo, input int hi, input int drop_pct);
    repeat (n) send_obs(rand_obs(lo, hi, drop_pct));
  endtask

  task automatic test_directed();
    cell_obs_t list [$];
    send_pace = 1'b0;
    sink_pace = 1'b1;
    list = {list, mk_obs(0, 0, 1000, 1000, 5)};
    list = {list, mk_obs(0, 1, 131071, -131072, 32'hFFFF_FFFF)};
    list = {list, mk_obs(0, 1, 0, 32768, 1)};
    list = {list, mk_obs(0, 0, 0, 0, 0)};
    list = {list, mk_obs(0, 1, -1, 32769, 7)};
    list = {list, mk_obs(1023, 1, 0, 32768, 0)};
    list = {list, mk_obs(1023, 1, 32768, 32768, 0)};
    list = {list, mk_obs(1023, 1, 32767, 131071, 3)};
    list = {list, mk_obs(1023, 1, -131072, 0, 0)};
    list = {list, mk_obs(512, 1, 16384, 16384, 100)};
    list = {list, mk_obs(512, 1, 16384, 16384, 100)};
    list = {list, mk_obs(512, 1, 32769, 1, 0)};
    list = {list, mk_obs(512, 1, 1, 32767, 32'h8000_0000)};
    list = {list, mk_obs(512, 1, 20000, 65536, 32'h8000_0000)};
    list = {list, mk_obs(10'h155, 1, 18'h2AAAA, 18'h15555, 32'hAAAA_AAAA)};
    list = {list, mk_obs(10'h2AA, 1, 18'h15555, 18'h2AAAA, 32'h5555_5555)};
    list = {list, mk_obs(10'h2AA, 1, 100, 32768, 1)};
    list = {list, mk_obs(1, 1, 32768, 32768, 0)};
    list = {list, mk_obs(1, 1, 0, 32768, 0)};
    list = {list, mk_obs(1, 0, 18'h1FFFF, 18'h1FFFF, 32'hFFFF_FFFF)};
    list = {list, mk_obs(2, 0, 18'h3FFFF, 18'h3FFFF, 32'hFFFF_FFFF)};
    list = {list, mk_obs(0, 1, 32768, 32768, 0)};
    list = {list, mk_obs(0, 1, 0, 16384, 0)};
    foreach (list[i]) send_obs(list[i]);
    wait_drained();
  endtask

  task automatic test_gain_settings();
    logic [Q_W-1:0] rise_set [7];
    logic [Q_W-1:0] fall_set [7];
    rise_set = '{16'd0, 16'd32768, 16'd65535, 16'd0,     16'd1,     16'd0, 16'd22938};
    fall_set = '{16'd0, 16'd32768, 16'd32769, 16'd65535, 16'd32767, 16'd0, 16'd4915};
    rise_set[5] = 16'($urandom);
    fall_set[5] = 16'($urandom_range(0, 32768));
    send_pace = 1'b1;
    sink_pace = 1'b1;
    foreach (rise_set[i]) begin
      write_gain(REG_RISE_GAIN, rise_set[i]);
      write_gain(REG_FALL_GAIN, fall_set[i]);
      run_batch(18, 0, 15, 5);
      wait_drained();
    end
  endtask

  task automatic test_random();
    send_pace = 1'b0;
    sink_pace = 1'b1;
    run_batch(150, 0, 7, 10);
    wait_drained();
    send_pace = 1'b1;
    run_batch(150, 0, CELLS - 1, 10);
    wait_drained();
    write_gain(REG_RISE_GAIN, 16'($urandom_range(0, 32768)));
    write_gain(REG_FALL_GAIN, 16'($urandom_range(0, 32768)));
    sink_pace = 1'b0;
    run_batch(150, 100, 131, 10);
    wait_drained();
    sink_pace = 1'b1;
    repeat (50) begin
      cell_obs_t o;
      o = rand_obs(0, CELLS - 1, 50);
      o.cost_raw = RAW_W'($urandom);
      o.conf_raw = RAW_W'($urandom);
      o.samples  = CNT_W'($urandom);
      send_obs(o);
    end
    wait_drained();
  endtask

  task automatic flag_mismatch(input string msg);
    if (mismatch_cnt < 10) $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  always @(posedge clk_i) begin
    cell_snapshot_t want;
    logic [Q_W-1:0]   got_cost;
    logic [Q_W-1:0]   got_conf;
    logic [CNT_W-1:0] got_count;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_cost  = m_axis_tdata[15:0];
      got_conf  = m_axis_tdata[31:16];
      got_count = m_axis_tdata[63:32];
      updates_seen++;
      if (pending_cells.size() == 0) begin
        flag_mismatch($sformatf("result with none pending: ign=%0b cost=%0d conf=%0d n=%0d",
                                m_axis_tuser, got_cost, got_conf, got_count));
      end else begin
        want = pending_cells.pop_front();
        if (m_axis_tuser !== want.ignored)
          flag_mismatch($sformatf("ignored exp %0b got %0b", want.ignored, m_axis_tuser));
        if (got_cost !== want.cost)
          flag_mismatch($sformatf("cost exp %0d got %0d", want.cost, got_cost));
        if (got_conf !== want.conf)
          flag_mismatch($sformatf("confidence exp %0d got %0d", want.conf, got_conf));
        if (got_count !== want.count)
          flag_mismatch($sformatf("observations exp %0d got %0d", want.count, got_count));
      end
    end
  end

  always @(negedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
      if (sink_pace && $urandom_range(0, 99) < 30) sink_hold <= gap_len();
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (psel && penable && pwrite && pready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    rise_gain_q   = RISE_GAIN_INIT;
    fall_gain_q   = FALL_GAIN_INIT;
    sink_hold     = 0;
    send_pace     = 1'b0;
    sink_pace     = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_gain_settings();
    test_random();

    $display("covered %0d observations, %0d dropped as non-finite, %0d saturating counts",
             obs_sent, dropped_cnt, saturated_cnt);
    $display("checked %0d results across %0d gain register writes", updates_seen, reg_writes);
    if (mismatch_cnt == 0 && pending_cells.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
